[rtl/gdc_pkg.sv]
// ----------------------------------------------------------------------------
// Gamepad conditioner package
// Request types, register indexes, link codes, datapath widths and the
// sequencer state type shared by the conditioner RTL.
// ----------------------------------------------------------------------------
package gdc_pkg;

    typedef struct packed {
        logic               pad_present;
        logic        [15:0] button_bits;
        logic signed [15:0] left_stick_x;
        logic signed [15:0] left_stick_y;
        logic signed [15:0] right_stick_x;
        logic signed [15:0] right_stick_y;
        logic        [7:0]  left_trigger_raw;
        logic        [7:0]  right_trigger_raw;
    } in_item_t;

    typedef struct packed {
        logic        [1:0]  link_event;
        logic               link_up;
        logic        [15:0] buttons_pressed;
        logic        [15:0] buttons_released;
        logic signed [15:0] left_out_x;
        logic signed [15:0] left_out_y;
        logic signed [15:0] right_out_x;
        logic signed [15:0] right_out_y;
        logic        [15:0] left_trigger_level;
        logic        [15:0] right_trigger_level;
        logic               state_changed;
    } out_item_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LEFT_DZ    = 2'd0;
    localparam logic [1:0] CFG_RIGHT_DZ   = 2'd1;
    localparam logic [1:0] CFG_TRIG_THR   = 2'd2;
    localparam logic [1:0] CFG_WATCH_MASK = 2'd3;

    // Link event codes.
    localparam logic [1:0] LINK_NONE = 2'd0;
    localparam logic [1:0] LINK_CONN = 2'd1;
    localparam logic [1:0] LINK_DISC = 2'd2;

    localparam logic [14:0] STICK_FULL = 15'h7FFF;
    localparam logic [7:0]  TRIG_MAX   = 8'd255;
    localparam logic [15:0] TRIG_FULL  = 16'hFFFF;

    // Datapath widths.
    localparam int S_W    = 31;  // x*x + y*y
    localparam int V_W    = 48;  // radicand shift register, S << 16 padded
    localparam int SREM_W = 26;  // square root remainder
    localparam int ROOT_W = 24;  // magnitude with 8 fraction bits
    localparam int FNUM_W = 23;  // rescale numerator
    localparam int DEN_W  = 39;  // rescale denominator
    localparam int A_W    = 30;  // |v| * 32767
    localparam int NUM_W  = 53;  // dividend base
    localparam int N_W    = 55;  // 2*num + den
    localparam int D_W    = 40;  // 2*den, also divider remainder width
    localparam int Q_W    = 17;  // quotient bits

    localparam logic [ROOT_W-1:0] STICK_MC = 24'd8388352;  // 32767 * 256

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_DZ,
        ST_CHK,
        ST_SQRT,
        ST_DEN,
        ST_NUMA,
        ST_NUMB,
        ST_DIVINIT,
        ST_DIV,
        ST_TRIG,
        ST_FIN
    } state_t;

endpackage

[rtl/gamepad_deadzone_conditioner.sv]
// ----------------------------------------------------------------------------
// Gamepad dead zone conditioner
// Link edges, watched button edges, radial stick dead zone with rescale and
// trigger threshold with rescale, using a bit-serial square root and a
// bit-serial divider shared by all six outputs.
// ----------------------------------------------------------------------------
//  channel   | signals                         | moves
//  in        | in_valid, in_ready, in_data     | one controller poll request
//  out       | out_valid, out_ready, out_data  | one conditioned result
//  cfg       | cfg_we, cfg_index, cfg_data     | one register write
//
// An absent pad goes straight to the result step. For a present pad, each
// stick runs setup (x squared, the sum, the dead zone squared and a check),
// the square root (one result bit per cycle), the denominator and, per axis,
// two numerator steps and the shared restoring divider; each trigger runs a
// threshold step and the divider; a stick inside its dead zone or a trigger
// needing no division skips the rest. Reset clears the configuration and the
// previous-poll state. A request is taken while a finished result still waits in
// the output register; a stalled output holds the sequencer only at its final step.
module gamepad_deadzone_conditioner (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  gdc_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output gdc_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    gdc_pkg::state_t state_reg, state_next;
    logic [2:0]  job_reg, job_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic        was_conn_reg, was_conn_next;
    logic [15:0] prev_btn_reg, prev_btn_next;
    logic [15:0] prev_out_reg [6];
    logic [15:0] prev_out_next [6];
    logic [14:0] left_dz_reg, right_dz_reg;
    logic [7:0]  thr_reg;
    logic [15:0] mask_reg;

    gdc_pkg::in_item_t  in_reg, in_next;
    gdc_pkg::out_item_t out_reg, out_next;
    logic [29:0]                 prod_reg, prod_next;
    logic [gdc_pkg::S_W-1:0]     s_reg, s_next;
    logic [gdc_pkg::V_W-1:0]     vsh_reg, vsh_next;
    logic [gdc_pkg::SREM_W-1:0]  srem_reg, srem_next;
    logic [gdc_pkg::ROOT_W-1:0]  root_reg, root_next;
    logic [gdc_pkg::FNUM_W-1:0]  fnum_reg, fnum_next;
    logic [gdc_pkg::DEN_W-1:0]   den_reg, den_next;
    logic [gdc_pkg::A_W-1:0]     a_reg, a_next;
    logic [gdc_pkg::NUM_W-1:0]   num_reg, num_next;
    logic [gdc_pkg::Q_W-1:0]     nsh_reg, nsh_next;
    logic [gdc_pkg::D_W-1:0]     drem_reg, drem_next;
    logic [gdc_pkg::D_W-1:0]     d_reg, d_next;
    logic [gdc_pkg::Q_W-1:0]     q_reg, q_next;
    logic [15:0] res_reg [6];
    logic [15:0] res_next [6];

    function automatic logic [14:0] clamp_abs(input logic signed [15:0] v);
        logic [15:0] neg;
        neg = 16'd0 - v;
        if (v == -16'sd32768)
            return 15'h7FFF;
        else if (v < 0)
            return neg[14:0];
        else
            return v[14:0];
    endfunction

    logic signed [15:0] raw_x, raw_y;
    logic [14:0] ax, ay, dz_sel, axis_abs, dz_span;
    logic        axis_neg;
    logic [7:0]  trig_raw, trig_diff;
    logic [29:0] ay_sq;
    logic [27:0] srem_t, strial;
    logic        sge;
    logic [gdc_pkg::D_W:0] dt, ddiff;
    logic        dge;
    logic [gdc_pkg::Q_W-1:0] q_fin;
    logic [14:0] q_sat;
    logic [15:0] q_mag, axis_res;
    logic [gdc_pkg::N_W-1:0] n_full;
    logic [gdc_pkg::FNUM_W-1:0] mc;
    logic        changed;

    always_comb
    begin
        raw_x     = job_reg[1] ? in_reg.right_stick_x : in_reg.left_stick_x;
        raw_y     = job_reg[1] ? in_reg.right_stick_y : in_reg.left_stick_y;
        ax        = clamp_abs(raw_x);
        ay        = clamp_abs(raw_y);
        dz_sel    = job_reg[1] ? right_dz_reg : left_dz_reg;
        dz_span   = gdc_pkg::STICK_FULL - dz_sel;
        axis_abs  = job_reg[0] ? ay : ax;
        axis_neg  = job_reg[0] ? raw_y[15] : raw_x[15];
        trig_raw  = job_reg[0] ? in_reg.right_trigger_raw : in_reg.left_trigger_raw;
        trig_diff = trig_raw - thr_reg;
        ay_sq     = 30'(ay) * 30'(ay);

        srem_t = {srem_reg, vsh_reg[gdc_pkg::V_W-1 -: 2]};
        strial = {2'b00, root_reg, 2'b01};
        sge    = srem_t >= strial;

        dt    = {drem_reg, nsh_reg[gdc_pkg::Q_W-1]};
        dge   = dt >= {1'b0, d_reg};
        ddiff = dt - {1'b0, d_reg};
        q_fin = {q_reg[gdc_pkg::Q_W-2:0], dge};
        q_sat = (q_fin > 17'(gdc_pkg::STICK_FULL)) ? gdc_pkg::STICK_FULL : q_fin[14:0];
        q_mag = {1'b0, q_sat};
        axis_res = axis_neg ? 16'd0 - q_mag : q_mag;

        n_full = {1'b0, num_reg, 1'b0} + gdc_pkg::N_W'(den_reg);
        mc     = (root_reg >= gdc_pkg::STICK_MC) ? gdc_pkg::STICK_MC[gdc_pkg::FNUM_W-1:0]
                                                 : root_reg[gdc_pkg::FNUM_W-1:0];
    end

    // Sequencer and datapath next state.
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        cnt_next       = cnt_reg;
        in_next        = in_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        was_conn_next  = was_conn_reg;
        prev_btn_next  = prev_btn_reg;
        prev_out_next  = prev_out_reg;
        prod_next      = prod_reg;
        s_next         = s_reg;
        vsh_next       = vsh_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        fnum_next      = fnum_reg;
        den_next       = den_reg;
        a_next         = a_reg;
        num_next       = num_reg;
        nsh_next       = nsh_reg;
        drem_next      = drem_reg;
        d_next         = d_reg;
        q_next         = q_reg;
        res_next       = res_reg;
        changed        = 1'b0;
        in_ready       = (state_reg == gdc_pkg::ST_IDLE);

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            gdc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    in_next    = in_data;
                    job_next   = 3'd0;
                    state_next = in_data.pad_present ? gdc_pkg::ST_SQX : gdc_pkg::ST_FIN;
                end
            end
            gdc_pkg::ST_SQX:
            begin
                prod_next  = 30'(ax) * 30'(ax);
                state_next = gdc_pkg::ST_SQY;
            end
            gdc_pkg::ST_SQY:
            begin
                s_next     = gdc_pkg::S_W'(prod_reg) + gdc_pkg::S_W'(ay_sq);
                state_next = gdc_pkg::ST_DZ;
            end
            gdc_pkg::ST_DZ:
            begin
                prod_next  = 30'(dz_sel) * 30'(dz_sel);
                state_next = gdc_pkg::ST_CHK;
            end
            gdc_pkg::ST_CHK:
            begin
                if (s_reg == '0 || s_reg < gdc_pkg::S_W'(prod_reg))
                begin
                    // Inside the dead zone: both axes of this stick are zero.
                    res_next[job_reg]        = 16'd0;
                    res_next[job_reg + 3'd1] = 16'd0;
                    job_next   = job_reg + 3'd2;
                    state_next = job_reg[1] ? gdc_pkg::ST_TRIG : gdc_pkg::ST_SQX;
                end
                else
                begin
                    vsh_next   = {1'b0, s_reg, 16'd0};
                    srem_next  = '0;
                    root_next  = '0;
                    cnt_next   = 5'(gdc_pkg::ROOT_W - 1);
                    state_next = gdc_pkg::ST_SQRT;
                end
            end
            gdc_pkg::ST_SQRT:
            begin
                vsh_next = {vsh_reg[gdc_pkg::V_W-3:0], 2'b00};
                if (sge)
                begin
                    srem_next = gdc_pkg::SREM_W'(srem_t - strial);
                    root_next = {root_reg[gdc_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_next = gdc_pkg::SREM_W'(srem_t);
                    root_next = {root_reg[gdc_pkg::ROOT_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                    state_next = gdc_pkg::ST_DEN;
            end
            gdc_pkg::ST_DEN:
            begin
                // A full dead zone has a zero span; numerator and span are then both taken as one.
                if (dz_sel == gdc_pkg::STICK_FULL)
                begin
                    fnum_next = gdc_pkg::FNUM_W'(256);
                    den_next  = gdc_pkg::DEN_W'(root_reg);
                end
                else
                begin
                    fnum_next = mc - {dz_sel, 8'd0};
                    den_next  = gdc_pkg::DEN_W'(root_reg) * gdc_pkg::DEN_W'(dz_span);
                end
                state_next = gdc_pkg::ST_NUMA;
            end
            gdc_pkg::ST_NUMA:
            begin
                a_next     = {axis_abs, 15'd0} - gdc_pkg::A_W'(axis_abs);
                state_next = gdc_pkg::ST_NUMB;
            end
            gdc_pkg::ST_NUMB:
            begin
                num_next   = gdc_pkg::NUM_W'(a_reg) * gdc_pkg::NUM_W'(fnum_reg);
                state_next = gdc_pkg::ST_DIVINIT;
            end
            gdc_pkg::ST_DIVINIT:
            begin
                // Round half up: (2*num + den) / (2*den).
                drem_next  = gdc_pkg::D_W'(n_full[gdc_pkg::N_W-1:gdc_pkg::Q_W]);
                nsh_next   = n_full[gdc_pkg::Q_W-1:0];
                d_next     = {den_reg, 1'b0};
                q_next     = '0;
                cnt_next   = 5'(gdc_pkg::Q_W - 1);
                state_next = gdc_pkg::ST_DIV;
            end
            gdc_pkg::ST_DIV:
            begin
                drem_next = dge ? ddiff[gdc_pkg::D_W-1:0] : dt[gdc_pkg::D_W-1:0];
                nsh_next  = {nsh_reg[gdc_pkg::Q_W-2:0], 1'b0};
                q_next    = q_fin;
                cnt_next  = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    res_next[job_reg] = job_reg[2] ? q_fin[15:0] : axis_res;
                    job_next = job_reg + 3'd1;
                    priority case (job_reg)
                        3'd0, 3'd2: state_next = gdc_pkg::ST_NUMA;
                        3'd1:       state_next = gdc_pkg::ST_SQX;
                        3'd3, 3'd4: state_next = gdc_pkg::ST_TRIG;
                        default:    state_next = gdc_pkg::ST_FIN;
                    endcase
                end
            end
            gdc_pkg::ST_TRIG:
            begin
                if (trig_raw < thr_reg)
                begin
                    res_next[job_reg] = 16'd0;
                    job_next   = job_reg + 3'd1;
                    state_next = job_reg[0] ? gdc_pkg::ST_FIN : gdc_pkg::ST_TRIG;
                end
                else if (thr_reg == gdc_pkg::TRIG_MAX)
                begin
                    res_next[job_reg] = gdc_pkg::TRIG_FULL;
                    job_next   = job_reg + 3'd1;
                    state_next = job_reg[0] ? gdc_pkg::ST_FIN : gdc_pkg::ST_TRIG;
                end
                else
                begin
                    num_next   = gdc_pkg::NUM_W'({trig_diff, 16'd0} - 24'(trig_diff));
                    den_next   = gdc_pkg::DEN_W'(gdc_pkg::TRIG_MAX - thr_reg);
                    state_next = gdc_pkg::ST_DIVINIT;
                end
            end
            gdc_pkg::ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next = '0;
                    out_next.link_up = in_reg.pad_present;
                    if (!was_conn_reg && in_reg.pad_present)
                        out_next.link_event = gdc_pkg::LINK_CONN;
                    else if (was_conn_reg && !in_reg.pad_present)
                        out_next.link_event = gdc_pkg::LINK_DISC;
                    else
                        out_next.link_event = gdc_pkg::LINK_NONE;
                    if (in_reg.pad_present)
                    begin
                        changed = (in_reg.button_bits != prev_btn_reg);
                        for (int i = 0; i < 6; i++)
                            if (res_reg[i] != prev_out_reg[i])
                                changed = 1'b1;
                        out_next.buttons_pressed  = in_reg.button_bits & ~prev_btn_reg
                                                    & mask_reg;
                        out_next.buttons_released = prev_btn_reg & ~in_reg.button_bits
                                                    & mask_reg;
                        out_next.left_out_x          = res_reg[0];
                        out_next.left_out_y          = res_reg[1];
                        out_next.right_out_x         = res_reg[2];
                        out_next.right_out_y         = res_reg[3];
                        out_next.left_trigger_level  = res_reg[4];
                        out_next.right_trigger_level = res_reg[5];
                        out_next.state_changed       = changed;
                        prev_btn_next = in_reg.button_bits;
                        prev_out_next = res_reg;
                    end
                    was_conn_next  = in_reg.pad_present;
                    out_valid_next = 1'b1;
                    state_next     = gdc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gdc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gdc_pkg::ST_IDLE;
            job_reg       <= 3'd0;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
            was_conn_reg  <= 1'b0;
            prev_btn_reg  <= 16'd0;
            for (int i = 0; i < 6; i++)
                prev_out_reg[i] <= 16'd0;
            left_dz_reg   <= 15'd0;
            right_dz_reg  <= 15'd0;
            thr_reg       <= 8'd0;
            mask_reg      <= 16'd0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            was_conn_reg  <= was_conn_next;
            prev_btn_reg  <= prev_btn_next;
            prev_out_reg  <= prev_out_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    gdc_pkg::CFG_LEFT_DZ:    left_dz_reg  <= cfg_data[14:0];
                    gdc_pkg::CFG_RIGHT_DZ:   right_dz_reg <= cfg_data[14:0];
                    gdc_pkg::CFG_TRIG_THR:   thr_reg      <= cfg_data[7:0];
                    gdc_pkg::CFG_WATCH_MASK: mask_reg     <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg   <= in_next;
        out_reg  <= out_next;
        prod_reg <= prod_next;
        s_reg    <= s_next;
        vsh_reg  <= vsh_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        fnum_reg <= fnum_next;
        den_reg  <= den_next;
        a_reg    <= a_next;
        num_reg  <= num_next;
        nsh_reg  <= nsh_next;
        drem_reg <= drem_next;
        d_reg    <= d_next;
        q_reg    <= q_next;
        res_reg  <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    // While the sequencer works on a poll, only the six outputs are scheduled.
    a_job_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != gdc_pkg::ST_IDLE && state_reg != gdc_pkg::ST_FIN |->
            job_reg <= 3'd5)
        else $error("job index beyond the six outputs");

    // The divider remainder stays below the divisor, so the quotient fits.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gdc_pkg::ST_DIV |-> drem_reg < d_reg)
        else $error("divider remainder not below divisor");

    // A stick outside the dead zone has a nonzero sum, so its magnitude is at least one.
    a_root_min: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gdc_pkg::ST_DEN |-> root_reg >= 24'd256)
        else $error("stick magnitude below one");

    // A result for an absent pad carries only the link fields.
    a_absent_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.link_up |->
            !out_reg.state_changed && out_reg.buttons_pressed == 16'd0
            && out_reg.left_trigger_level == 16'd0)
        else $error("absent pad result carries conditioned data");
`endif

endmodule

[tb/tb_gamepad_deadzone_conditioner.sv]
// ----------------------------------------------------------------------------
// Gamepad dead zone conditioner testbench
// Drives controller polls through the valid/ready request channel under
// random gaps and output stalls. A behavioral predictor of the link, button
// edge, radial dead zone and trigger rescale logic computes each expected
// result, and the checker compares every result field by field.
// ----------------------------------------------------------------------------
module tb_gamepad_deadzone_conditioner;

    localparam int IDLE_LIMIT = 20000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    gdc_pkg::in_item_t   in_data;
    logic       out_valid;
    logic       out_ready;
    gdc_pkg::out_item_t  out_data;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    gamepad_deadzone_conditioner i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the registers and the previous-poll state.
    logic [14:0] left_dz;
    logic [14:0] right_dz;
    logic [7:0]  trig_thr;
    logic [15:0] watch_mask;
    logic        pad_was_up;
    logic [15:0] last_buttons;
    logic [15:0] last_sticks [4];
    logic [15:0] last_trigs [2];

    gdc_pkg::out_item_t expected_results [$];
    int          fail_count;
    int          idle_cycles;
    bit          hold_off;
    int          stall_mode;
    int          burst_left;

    always #6 clk = ~clk;

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] scale_axis(longint v, longint unsigned fnum,
                                               longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (v < 0) ? -v : v;
        q = (2 * mag * 32767 * fnum + den) / (2 * den);
        if (q > 32767)
            q = 32767;
        return (v < 0) ? 16'(-q) : 16'(q);
    endfunction

    task automatic condition_stick(logic signed [15:0] rx, logic signed [15:0] ry,
                                   logic [14:0] dz, output logic [15:0] ox,
                                   output logic [15:0] oy);
        longint x;
        longint y;
        longint unsigned s;
        longint unsigned m;
        longint unsigned mc;
        longint unsigned fnum;
        longint unsigned den;
        x = (rx < -32767) ? -32767 : rx;
        y = (ry < -32767) ? -32767 : ry;
        s = x * x + y * y;
        ox = '0;
        oy = '0;
        if (s == 0 || s < longint'(dz) * dz)
            return;
        m = isqrt(s << 16);
        if (m == 0)
            return;
        mc = (m < 32767 * 256) ? m : 32767 * 256;
        if (dz == 15'h7FFF)
        begin
            fnum = 256;
            den = m;
        end
        else
        begin
            fnum = mc - longint'(dz) * 256;
            den = m * (32767 - dz);
        end
        ox = scale_axis(x, fnum, den);
        oy = scale_axis(y, fnum, den);
    endtask

    function automatic logic [15:0] condition_trigger(logic [7:0] raw);
        longint unsigned span;
        if (raw < trig_thr)
            return '0;
        if (trig_thr == gdc_pkg::TRIG_MAX)
            return gdc_pkg::TRIG_FULL;
        span = 255 - trig_thr;
        return 16'((2 * 65535 * (raw - trig_thr) + span) / (2 * span));
    endfunction

    task automatic predict_poll(gdc_pkg::in_item_t p);
        gdc_pkg::out_item_t r;
        logic [15:0] sticks [4];
        logic [15:0] trigs [2];
        r = '0;
        if (!pad_was_up && p.pad_present)
            r.link_event = gdc_pkg::LINK_CONN;
        else if (pad_was_up && !p.pad_present)
            r.link_event = gdc_pkg::LINK_DISC;
        else
            r.link_event = gdc_pkg::LINK_NONE;
        r.link_up = p.pad_present;
        pad_was_up = p.pad_present;
        if (p.pad_present)
        begin
            r.buttons_pressed = p.button_bits & ~last_buttons & watch_mask;
            r.buttons_released = last_buttons & ~p.button_bits & watch_mask;
            condition_stick(p.left_stick_x, p.left_stick_y, left_dz, sticks[0], sticks[1]);
            condition_stick(p.right_stick_x, p.right_stick_y, right_dz,
                            sticks[2], sticks[3]);
            trigs[0] = condition_trigger(p.left_trigger_raw);
            trigs[1] = condition_trigger(p.right_trigger_raw);
            r.state_changed = (p.button_bits != last_buttons);
            for (int i = 0; i < 4; i++)
            begin
                if (sticks[i] != last_sticks[i])
                    r.state_changed = 1'b1;
                last_sticks[i] = sticks[i];
            end
            for (int i = 0; i < 2; i++)
            begin
                if (trigs[i] != last_trigs[i])
                    r.state_changed = 1'b1;
                last_trigs[i] = trigs[i];
            end
            r.left_out_x = sticks[0];
            r.left_out_y = sticks[1];
            r.right_out_x = sticks[2];
            r.right_out_y = sticks[3];
            r.left_trigger_level = trigs[0];
            r.right_trigger_level = trigs[1];
            last_buttons = p.button_bits;
        end
        expected_results.push_back(r);
    endtask

    // Sends one poll request, with the sender's own burst and gap pattern.
    // Valid stays high after acceptance so that a following request in the
    // same burst follows without a gap.
    task automatic send_poll(gdc_pkg::in_item_t p);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_poll(p);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            gdc_pkg::CFG_LEFT_DZ:    left_dz = val[14:0];
            gdc_pkg::CFG_RIGHT_DZ:   right_dz = val[14:0];
            gdc_pkg::CFG_TRIG_THR:   trig_thr = val[7:0];
            default:                 watch_mask = val;
        endcase
    endtask

    task automatic set_config(logic [14:0] ldz, logic [14:0] rdz, logic [7:0] thr,
                              logic [15:0] mask);
        wait_drained();
        write_reg(gdc_pkg::CFG_LEFT_DZ, {1'b0, ldz});
        write_reg(gdc_pkg::CFG_RIGHT_DZ, {1'b0, rdz});
        write_reg(gdc_pkg::CFG_TRIG_THR, {8'h00, thr});
        write_reg(gdc_pkg::CFG_WATCH_MASK, mask);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'($urandom_range(0, 600)) - 16'sd300;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic gdc_pkg::in_item_t rand_poll(bit present);
        gdc_pkg::in_item_t p;
        p.pad_present = present;
        p.button_bits = ($urandom_range(0, 1) == 0)
                        ? last_buttons ^ (16'h1 << $urandom_range(0, 15))
                        : 16'($urandom);
        p.left_stick_x = rand_axis();
        p.left_stick_y = rand_axis();
        p.right_stick_x = rand_axis();
        p.right_stick_y = rand_axis();
        p.left_trigger_raw = ($urandom_range(0, 4) == 0) ? 8'd255 : 8'($urandom);
        p.right_trigger_raw = ($urandom_range(0, 4) == 0) ? trig_thr : 8'($urandom);
        return p;
    endfunction

    function automatic gdc_pkg::in_item_t make_poll(logic [15:0] btn,
        logic signed [15:0] lx, logic signed [15:0] ly, logic signed [15:0] rx,
        logic signed [15:0] ry, logic [7:0] lt, logic [7:0] rt);
        return {1'b1, btn, lx, ly, rx, ry, lt, rt};
    endfunction

    task automatic test_link_edges();
        gdc_pkg::in_item_t p;
        p = rand_poll(1'b0);
        send_poll(p);
        send_poll(make_poll(16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000,
                            8'd255, 8'd0));
        send_poll(rand_poll(1'b0));
        send_poll(rand_poll(1'b0));
        send_poll(make_poll(16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0, 8'd0));
        send_poll(make_poll(16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0, 8'd0));
    endtask

    task automatic test_dead_zone_edges();
        set_config(15'd1000, 15'h7FFF, 8'd255, 16'hA5A5);
        send_poll(make_poll(16'hFFFF, 16'sd1000, 16'sd0, 16'sd100, 16'sd0, 8'd255, 8'd254));
        send_poll(make_poll(16'h0000, 16'sd999, 16'sd0, 16'sh8000, 16'sh8000,
                            8'd255, 8'd255));
        send_poll(make_poll(16'h5A5A, 16'sd600, 16'sd800, 16'sh7FFF, 16'sd1, 8'd0, 8'd7));
        send_poll(rand_poll(1'b0));
        send_poll(make_poll(16'h5A5A, 16'sh8000, 16'sh7FFF, 16'sd1, 16'sd0, 8'd128, 8'd0));
        set_config(15'h7FFF, 15'd0, 8'd0, 16'hFFFF);
        send_poll(make_poll(16'h0001, 16'sh7FFF, 16'sh7FFF, 16'sd1, 16'sd1, 8'd1, 8'd255));
        send_poll(make_poll(16'h8000, 16'sh7FFF, 16'sd0, 16'sh8000, 16'sd3, 8'd0, 8'd255));
    endtask

    task automatic test_random_polls();
        bit present;
        present = 1'b1;
        for (int n = 0; n < 1300; n++)
        begin
            if (n % 260 == 259)
                set_config(15'($urandom_range(0, 32767)),
                           ($urandom_range(0, 1) == 0) ? 15'h7FFF : 15'($urandom_range(0, 4000)),
                           ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom),
                           16'($urandom));
            if (n == 400)
                hold_off = 1'b1;
            if (n == 700)
                wait_drained();
            if ($urandom_range(0, 15) == 0)
                present = ~present;
            send_poll(rand_poll(present));
        end
    endtask

    // Receiver stall pattern, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_off)
        begin
            out_ready <= 1'b0;
            hold_off = 1'b0;
            repeat (3000) @(posedge clk);
            stall_mode <= 1;
        end
        else
        begin
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 2) != 0);
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
            if ($urandom_range(0, 99) == 0)
                stall_mode <= $urandom_range(0, 2);
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        gdc_pkg::out_item_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no expectation waiting: %h", out_data);
                fail_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (out_data.link_event !== exp_r.link_event)
                begin
                    $error("link_event exp %0d got %0d", exp_r.link_event, out_data.link_event);
                    fail_count++;
                end
                if (out_data.link_up !== exp_r.link_up)
                begin
                    $error("link_up exp %0d got %0d", exp_r.link_up, out_data.link_up);
                    fail_count++;
                end
                if (out_data.buttons_pressed !== exp_r.buttons_pressed)
                begin
                    $error("buttons_pressed exp %h got %h", exp_r.buttons_pressed,
                           out_data.buttons_pressed);
                    fail_count++;
                end
                if (out_data.buttons_released !== exp_r.buttons_released)
                begin
                    $error("buttons_released exp %h got %h", exp_r.buttons_released,
                           out_data.buttons_released);
                    fail_count++;
                end
                if (out_data.left_out_x !== exp_r.left_out_x)
                begin
                    $error("left_out_x exp %0d got %0d", exp_r.left_out_x, out_data.left_out_x);
                    fail_count++;
                end
                if (out_data.left_out_y !== exp_r.left_out_y)
                begin
                    $error("left_out_y exp %0d got %0d", exp_r.left_out_y, out_data.left_out_y);
                    fail_count++;
                end
                if (out_data.right_out_x !== exp_r.right_out_x)
                begin
                    $error("right_out_x exp %0d got %0d", exp_r.right_out_x,
                           out_data.right_out_x);
                    fail_count++;
                end
                if (out_data.right_out_y !== exp_r.right_out_y)
                begin
                    $error("right_out_y exp %0d got %0d", exp_r.right_out_y,
                           out_data.right_out_y);
                    fail_count++;
                end
                if (out_data.left_trigger_level !== exp_r.left_trigger_level)
                begin
                    $error("left_trigger_level exp %0d got %0d", exp_r.left_trigger_level,
                           out_data.left_trigger_level);
                    fail_count++;
                end
                if (out_data.right_trigger_level !== exp_r.right_trigger_level)
                begin
                    $error("right_trigger_level exp %0d got %0d", exp_r.right_trigger_level,
                           out_data.right_trigger_level);
                    fail_count++;
                end
                if (out_data.state_changed !== exp_r.state_changed)
                begin
                    $error("state_changed exp %0d got %0d", exp_r.state_changed,
                           out_data.state_changed);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted request, result or register write.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = gdc_pkg::CFG_LEFT_DZ;
        cfg_data = '0;
        fail_count = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        stall_mode = 0;
        burst_left = 0;
        left_dz = '0;
        right_dz = '0;
        trig_thr = '0;
        watch_mask = '0;
        pad_was_up = 1'b0;
        last_buttons = '0;
        for (int i = 0; i < 4; i++)
            last_sticks[i] = '0;
        for (int i = 0; i < 2; i++)
            last_trigs[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_link_edges();
        test_dead_zone_edges();
        test_random_polls();
        wait_drained();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
